// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, sampled on the rising clock edge outside reset
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/tpp_pkg.sv =====
`timescale 1ns / 1ps
package tpp_pkg;

   // virtual channel count saturates here
   localparam int MAX_VIRTUALS = 32;
   localparam int VREM_W       = $clog2(MAX_VIRTUALS + 1);

   // queue between parser and result sequencer
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] HEADER_BYTES = 8'd20;
   localparam logic [5:0] HDR_FLAGS_IDX = 6'd6;

   typedef enum logic [3:0] {
      SEC_HEADER   = 4'd0,
      SEC_ADC      = 4'd1,
      SEC_OUTPUTS  = 4'd2,
      SEC_HBRIDGE  = 4'd3,
      SEC_DIN      = 4'd4,
      SEC_VENTRY   = 4'd5,
      SEC_FAULTS   = 4'd6,
      SEC_CURRENTS = 4'd7,
      SEC_VCOUNT   = 4'd8,
      SEC_DONE     = 4'd9
   } section_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_TRUNC = 2'd2
   } status_type;

   typedef enum logic {
      KIND_FIELD  = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   // results caused by one accepted byte
   typedef struct packed {
      logic        has_field;
      section_type section;
      logic [5:0]  idx;
      logic [15:0] id;
      logic [31:0] value;
      logic        has_status;
      status_type  status;
   } record_type;

   // one result transaction
   typedef struct packed {
      kind_type    kind;
      section_type section;
      logic [5:0]  idx;
      logic [15:0] id;
      logic [31:0] value;
      status_type  status;
      logic        last;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // section at a given position of the optional section order
   function automatic section_type order_section(input logic [2:0] pos);
      section_type sec;
      case (pos)
         3'd0:    sec = SEC_ADC;
         3'd1:    sec = SEC_OUTPUTS;
         3'd2:    sec = SEC_HBRIDGE;
         3'd3:    sec = SEC_DIN;
         3'd4:    sec = SEC_VCOUNT;
         3'd5:    sec = SEC_FAULTS;
         3'd6:    sec = SEC_CURRENTS;
         default: sec = SEC_DONE;
      endcase
      return sec;
   endfunction

   // position of a section in the order
   function automatic logic [2:0] order_pos(input section_type sec);
      logic [2:0] pos;
      case (sec)
         SEC_ADC:     pos = 3'd0;
         SEC_OUTPUTS: pos = 3'd1;
         SEC_HBRIDGE: pos = 3'd2;
         SEC_DIN:     pos = 3'd3;
         SEC_VCOUNT:  pos = 3'd4;
         SEC_VENTRY:  pos = 3'd4;
         SEC_FAULTS:  pos = 3'd5;
         default:     pos = 3'd6;
      endcase
      return pos;
   endfunction

   // minimum bytes contributed by each optional section
   function automatic logic [7:0] section_bytes(input logic [2:0] pos);
      logic [7:0] n;
      case (pos)
         3'd0:    n = 8'd40;
         3'd1:    n = 8'd30;
         3'd2:    n = 8'd16;
         3'd3:    n = 8'd4;
         3'd4:    n = 8'd2;
         3'd5:    n = 8'd4;
         3'd6:    n = 8'd60;
         default: n = 8'd0;
      endcase
      return n;
   endfunction

   // first enabled section at order position from or later
   function automatic section_type first_enabled(input logic [6:0] flags,
                                                 input logic [2:0] from);
      section_type sec;
      sec = SEC_DONE;
      for (int p = 6; p >= 0; p--) begin
         if (flags[p] && (3'(p) >= from)) begin
            sec = order_section(3'(p));
         end
      end
      return sec;
   endfunction

   // packet length needed by the enabled sections
   function automatic logic [7:0] min_size_of(input logic [6:0] flags);
      logic [7:0] sum;
      sum = HEADER_BYTES;
      for (int p = 0; p < 7; p++) begin
         if (flags[p]) begin
            sum = sum + section_bytes(3'(p));
         end
      end
      return sum;
   endfunction

   // byte width of the field at this position
   function automatic logic [2:0] field_width(input section_type sec,
                                              input logic [5:0] idx);
      logic [2:0] w;
      case (sec)
         SEC_HEADER: begin
            if (idx inside {6'd0, 6'd1, 6'd5}) w = 3'd4;
            else w = 3'd2;
         end
         SEC_OUTPUTS: w = 3'd1;
         SEC_DIN:     w = 3'd4;
         SEC_VENTRY:  w = 3'd6;
         SEC_FAULTS: begin
            if (idx < 6'd2) w = 3'd1;
            else w = 3'd2;
         end
         default:     w = 3'd2;
      endcase
      return w;
   endfunction

   // number of fields in a fixed-size section
   function automatic logic [5:0] section_count(input section_type sec);
      logic [5:0] n;
      case (sec)
         SEC_ADC:      n = 6'd20;
         SEC_OUTPUTS:  n = 6'd30;
         SEC_CURRENTS: n = 6'd30;
         SEC_HBRIDGE:  n = 6'd8;
         SEC_FAULTS:   n = 6'd3;
         default:      n = 6'd1;
      endcase
      return n;
   endfunction

   function automatic logic [31:0] sext16(input logic [31:0] v);
      return {{16{v[15]}}, v[15:0]};
   endfunction

endpackage

// ===== rtl/telemetry_packet_parser.sv =====
`timescale 1ns / 1ps
// Telemetry packet parser. Packet bytes enter one per cycle on the req channel while the queue
// has room, with tlast on the final byte. A 20-byte little-endian header is decoded, then the
// optional sections that the header's flags word enables; every field goes out on the rsp
// channel once its last byte arrives, and the end mark adds a status transaction (ok, too
// short or truncated) with tlast set on the final result of each byte. The parser takes one
// byte per cycle while the queue is not full, with its per-byte state update registered, and
// results leave through a 4-entry queue and an output register at one per cycle while the
// receiver is ready. A byte that both completes a field and ends the packet produces two
// results, the field and then its status, so input stalls only when the queue fills.
`include "assert_macros.svh"
module telemetry_packet_parser import tpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_packet
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [3:0] section, [9:4] element_index, [25:10] vchan_id,
                                    // [57:26] field_value, [59:58] status, [63:60] zero
   output logic        rsp_tuser,   // result_kind
   output logic        rsp_tlast    // last_of_run
);

   logic         take;
   logic         rec_valid;
   record_type   rec;
   record_type   head_rec;
   q_status_type q_stat;
   logic         pop;
   result_type   out_res;
   logic         rsp_take;

   // input transaction
   assign req_tready = !q_stat.full;
   assign take       = req_tvalid && req_tready;

   tpp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .data_byte     (req_tdata),
      .end_of_packet (req_tlast),
      .rec_valid     (rec_valid),
      .rec           (rec)
   );

   tpp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_valid),
      .push_rec (rec),
      .pop      (pop),
      .head_rec (head_rec),
      .q_stat   (q_stat)
   );

   tpp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_rec  (head_rec),
      .q_stat    (q_stat),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   // result packing
   assign rsp_tdata = {4'd0, out_res.status, out_res.value, out_res.id, out_res.idx,
                       out_res.section};
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.last;

   // result transaction
   assign rsp_take = rsp_tvalid && rsp_tready;

   // a field taken without tlast is followed at once by its status
   `ASSERT_NEXT(a_status_follows, rsp_take && !rsp_tlast, rsp_tvalid && rsp_tuser == KIND_STATUS)
   // a status always closes the results of its byte
   `ASSERT_IMP(a_status_last, rsp_tvalid && rsp_tuser == KIND_STATUS, rsp_tlast)
   // field results carry no status code
   `ASSERT_IMP(a_field_no_status, rsp_tvalid && rsp_tuser == KIND_FIELD, rsp_tdata[59:58] == ST_OK)

endmodule

// ===== rtl/tpp_front.sv =====
`timescale 1ns / 1ps
module tpp_front import tpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [7:0]  data_byte,
   input  logic        end_of_packet,
   output logic        rec_valid,
   output record_type  rec
);

   logic [15:0]       byte_count_ff, byte_count_in;
   logic [6:0]        flags_ff, flags_in;
   section_type       sec_ff, sec_in;
   logic [5:0]        elem_ff, elem_in;
   logic [2:0]        bif_ff, bif_in;
   logic [47:0]       asm_ff, asm_in;
   logic [VREM_W-1:0] vrem_ff, vrem_in;
   logic [7:0]        min_size_ff, min_size_in;

   logic [2:0]        width;
   logic [47:0]       asm_upd;
   logic              field_done;
   logic [31:0]       lo;
   logic [15:0]       byte_count_upd;
   logic [VREM_W-1:0] cnt_sat;
   section_type       sec_after;
   logic [7:0]        min_after;

   // byte assembly into the current field
   always_comb begin
      width          = field_width(sec_ff, elem_ff);
      asm_upd        = asm_ff | (48'(data_byte) << {bif_ff, 3'b000});
      field_done     = (sec_ff != SEC_DONE) && (bif_ff == width - 3'd1);
      lo             = asm_upd[31:0];
      byte_count_upd = (byte_count_ff != 16'hFFFF) ? byte_count_ff + 16'd1 : byte_count_ff;
      if (lo[15:0] > 16'(MAX_VIRTUALS)) cnt_sat = VREM_W'(MAX_VIRTUALS);
      else cnt_sat = lo[VREM_W-1:0];
   end

   // next state of the parser
   always_comb begin
      byte_count_in = byte_count_ff;
      flags_in      = flags_ff;
      sec_after     = sec_ff;
      elem_in       = elem_ff;
      bif_in        = bif_ff;
      asm_in        = asm_ff;
      vrem_in       = vrem_ff;
      min_after     = min_size_ff;
      if (take) begin
         byte_count_in = byte_count_upd;
         if (sec_ff != SEC_DONE) begin
            if (!field_done) begin
               bif_in = bif_ff + 3'd1;
               asm_in = asm_upd;
            end else begin
               bif_in = 3'd0;
               asm_in = '0;
               case (sec_ff)
                  SEC_HEADER: begin
                     if (elem_ff >= HDR_FLAGS_IDX) begin
                        flags_in  = lo[6:0];
                        min_after = min_size_of(lo[6:0]);
                        sec_after = first_enabled(lo[6:0], 3'd0);
                        elem_in   = 6'd0;
                     end else begin
                        elem_in = elem_ff + 6'd1;
                     end
                  end
                  SEC_VCOUNT: begin
                     vrem_in = cnt_sat;
                     elem_in = 6'd0;
                     if (cnt_sat != '0) sec_after = SEC_VENTRY;
                     else sec_after = first_enabled(flags_ff, 3'd5);
                  end
                  SEC_VENTRY: begin
                     if (vrem_ff != '0) vrem_in = vrem_ff - VREM_W'(1);
                     elem_in = elem_ff + 6'd1;
                     if (vrem_ff <= VREM_W'(1)) begin
                        sec_after = first_enabled(flags_ff, 3'd5);
                        elem_in   = 6'd0;
                     end
                  end
                  default: begin
                     if (elem_ff >= section_count(sec_ff) - 6'd1) begin
                        sec_after = first_enabled(flags_ff, order_pos(sec_ff) + 3'd1);
                        elem_in   = 6'd0;
                     end else begin
                        elem_in = elem_ff + 6'd1;
                     end
                  end
               endcase
            end
         end
      end
      sec_in      = sec_after;
      min_size_in = min_after;
      // end mark returns the parser to its reset state
      if (take && end_of_packet) begin
         byte_count_in = '0;
         flags_in      = '0;
         sec_in        = SEC_HEADER;
         elem_in       = '0;
         bif_in        = '0;
         asm_in        = '0;
         vrem_in       = '0;
         min_size_in   = HEADER_BYTES;
      end
   end

   // results of this byte
   always_comb begin
      rec            = '0;
      rec.has_field  = take && field_done;
      rec.section    = sec_ff;
      rec.idx        = (sec_ff == SEC_VCOUNT) ? 6'd0 : elem_ff;
      rec.id         = (sec_ff == SEC_VENTRY) ? lo[15:0] : 16'd0;
      case (sec_ff)
         SEC_HEADER: begin
            if (elem_ff inside {6'd3, 6'd4}) rec.value = sext16(lo);
            else rec.value = lo;
         end
         SEC_HBRIDGE: begin
            if (elem_ff < 6'd4) rec.value = sext16(lo);
            else rec.value = lo;
         end
         SEC_VCOUNT: rec.value = 32'(cnt_sat);
         SEC_VENTRY: rec.value = asm_upd[47:16];
         default:    rec.value = lo;
      endcase
      rec.has_status = take && end_of_packet;
      if (byte_count_upd < {8'd0, min_after}) rec.status = ST_SHORT;
      else if (sec_after != SEC_DONE) rec.status = ST_TRUNC;
      else rec.status = ST_OK;
      rec_valid = rec.has_field || rec.has_status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         flags_ff      <= '0;
         sec_ff        <= SEC_HEADER;
         elem_ff       <= '0;
         bif_ff        <= '0;
         asm_ff        <= '0;
         vrem_ff       <= '0;
         min_size_ff   <= HEADER_BYTES;
      end else begin
         byte_count_ff <= byte_count_in;
         flags_ff      <= flags_in;
         sec_ff        <= sec_in;
         elem_ff       <= elem_in;
         bif_ff        <= bif_in;
         asm_ff        <= asm_in;
         vrem_ff       <= vrem_in;
         min_size_ff   <= min_size_in;
      end
   end

endmodule

// ===== rtl/tpp_queue.sv =====
`timescale 1ns / 1ps
module tpp_queue import tpp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  record_type   push_rec,
   input  logic         pop,
   output record_type   head_rec,
   output q_status_type q_stat
);

   record_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head_rec     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// ===== rtl/tpp_back.sv =====
`timescale 1ns / 1ps
module tpp_back import tpp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  record_type   head_rec,
   input  q_status_type q_stat,
   output logic         pop,
   output logic         out_valid,
   input  logic         out_ready,
   output result_type   out_res
);

   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       pend_ff, pend_in;
   status_type pend_status_ff, pend_status_in;
   logic       load;

   // output register refills when empty or being taken
   always_comb begin
      load           = !out_valid_ff || out_ready;
      pop            = load && !pend_ff && !q_stat.empty;
      out_valid_in   = out_valid_ff;
      out_in         = out_ff;
      pend_in        = pend_ff;
      pend_status_in = pend_status_ff;
      if (load) begin
         out_valid_in = 1'b0;
         if (pend_ff) begin
            // deferred status after a field of the same byte
            out_valid_in   = 1'b1;
            out_in         = '0;
            out_in.kind    = KIND_STATUS;
            out_in.section = SEC_HEADER;
            out_in.status  = pend_status_ff;
            out_in.last    = 1'b1;
            pend_in        = 1'b0;
         end else if (!q_stat.empty) begin
            out_valid_in = 1'b1;
            out_in       = '0;
            if (head_rec.has_field) begin
               out_in.kind    = KIND_FIELD;
               out_in.section = head_rec.section;
               out_in.idx     = head_rec.idx;
               out_in.id      = head_rec.id;
               out_in.value   = head_rec.value;
               out_in.status  = ST_OK;
               out_in.last    = !head_rec.has_status;
               pend_in        = head_rec.has_status;
               pend_status_in = head_rec.status;
            end else begin
               out_in.kind    = KIND_STATUS;
               out_in.section = SEC_HEADER;
               out_in.status  = head_rec.status;
               out_in.last    = 1'b1;
            end
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_res   = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_ff         <= out_in;
      pend_status_ff <= pend_status_in;
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import tpp_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] data_byte
   logic        req_tlast = 1'b0;   // end_of_packet
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;          // [3:0] section, [9:4] element_index, [25:10] vchan_id,
                                    // [57:26] field_value, [59:58] status, [63:60] zero
   logic        rsp_tuser;          // result_kind
   logic        rsp_tlast;          // last_of_run

   telemetry_packet_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // one byte waiting to be sent
   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       drain;   // hold until every awaited result has come
      logic       nogap;   // send without idle cycles
   } byte_item_type;

   byte_item_type packet_bytes[$];
   logic [7:0]    pkt[$];
   result_type    awaited_results[$];
   int            mismatches = 0;

   // parser state mirrored in the testbench
   logic [15:0] byte_cnt;
   logic [15:0] flags_reg;
   section_type cur_sec;
   logic [5:0]  elem_idx;
   logic [2:0]  fill_pos;
   logic [47:0] shift_reg;
   logic [15:0] vcount_left;
   logic [15:0] min_len;

   // idle pattern of each side: stretches with and without idle cycles
   int   drv_run = 0, mon_run = 0;
   logic drv_calm = 1'b0, mon_calm = 1'b0;
   int   gap_left = 0, stall_left = 0;

   task automatic draw_wait(inout int left, inout logic calm, output int w);
      if (left == 0) begin
         left = $urandom_range(8, 64);
         calm = ($urandom_range(0, 3) == 0);
      end
      left--;
      w = calm ? 0 : $urandom_range(0, 8);
   endtask

   task automatic clear_parser();
      byte_cnt    = '0;
      flags_reg   = '0;
      cur_sec     = SEC_HEADER;
      elem_idx    = '0;
      fill_pos    = '0;
      shift_reg   = '0;
      vcount_left = '0;
      min_len     = 16'd20;
   endtask

   function automatic logic [2:0] width_of(section_type s, logic [5:0] i);
      case (s)
         SEC_HEADER:  return (i == 6'd0 || i == 6'd1 || i == 6'd5) ? 3'd4 : 3'd2;
         SEC_OUTPUTS: return 3'd1;
         SEC_DIN:     return 3'd4;
         SEC_VENTRY:  return 3'd6;
         SEC_FAULTS:  return (i < 6'd2) ? 3'd1 : 3'd2;
         default:     return 3'd2;
      endcase
   endfunction

   // first enabled optional section at order position pos or later
   task automatic enter_from(input int pos);
      elem_idx = '0;
      cur_sec  = SEC_DONE;
      for (int p = 6; p >= pos; p--) begin
         if (flags_reg[p]) begin
            case (p)
               0:       cur_sec = SEC_ADC;
               1:       cur_sec = SEC_OUTPUTS;
               2:       cur_sec = SEC_HBRIDGE;
               3:       cur_sec = SEC_DIN;
               4:       cur_sec = SEC_VCOUNT;
               5:       cur_sec = SEC_FAULTS;
               default: cur_sec = SEC_CURRENTS;
            endcase
         end
      end
   endtask

   // decode one accepted byte and queue the results it causes
   task automatic decode_byte(input logic [7:0] b, input logic eop);
      result_type r;
      result_type outs[$];
      logic [2:0] w;
      logic [31:0] lo;
      logic [15:0] cnt;
      int n_fields, next_pos;
      if (byte_cnt != 16'hFFFF) byte_cnt++;
      if (cur_sec != SEC_DONE) begin
         w = width_of(cur_sec, elem_idx);
         if (fill_pos >= w) fill_pos = '0;
         shift_reg = shift_reg | (48'(b) << (8 * fill_pos));
         fill_pos++;
         if (fill_pos >= w) begin
            lo        = shift_reg[31:0];
            r         = '0;
            r.kind    = KIND_FIELD;
            r.section = cur_sec;
            r.idx     = elem_idx;
            case (cur_sec)
               SEC_HEADER: begin
                  // both temperatures are signed
                  if (elem_idx == 6'd3 || elem_idx == 6'd4) lo = {{16{lo[15]}}, lo[15:0]};
                  r.value = lo;
                  if (elem_idx >= 6'd6) begin
                     flags_reg = lo[15:0];
                     min_len   = 16'd20;
                     for (int p = 0; p < 7; p++) begin
                        if (flags_reg[p]) begin
                           case (p)
                              0:       min_len += 16'd40;
                              1:       min_len += 16'd30;
                              2:       min_len += 16'd16;
                              3:       min_len += 16'd4;
                              4:       min_len += 16'd2;
                              5:       min_len += 16'd4;
                              default: min_len += 16'd60;
                           endcase
                        end
                     end
                     enter_from(0);
                  end else begin
                     elem_idx++;
                  end
               end
               SEC_VCOUNT: begin
                  // count saturates at the entry limit
                  cnt = lo[15:0];
                  if (cnt > MAX_VIRTUALS) cnt = 16'(MAX_VIRTUALS);
                  r.value     = 32'(cnt);
                  vcount_left = cnt;
                  if (cnt != 16'd0) begin
                     cur_sec  = SEC_VENTRY;
                     elem_idx = '0;
                  end else begin
                     enter_from(5);
                  end
               end
               SEC_VENTRY: begin
                  r.id    = lo[15:0];
                  r.value = shift_reg[47:16];
                  if (vcount_left != 16'd0) vcount_left--;
                  elem_idx++;
                  if (vcount_left == 16'd0) enter_from(5);
               end
               default: begin
                  // h-bridge positions are signed
                  if (cur_sec == SEC_HBRIDGE && elem_idx < 6'd4) lo = {{16{lo[15]}}, lo[15:0]};
                  r.value = lo;
                  case (cur_sec)
                     SEC_ADC:     begin n_fields = 20; next_pos = 1; end
                     SEC_OUTPUTS: begin n_fields = 30; next_pos = 2; end
                     SEC_HBRIDGE: begin n_fields = 8;  next_pos = 3; end
                     SEC_DIN:     begin n_fields = 1;  next_pos = 4; end
                     SEC_FAULTS:  begin n_fields = 3;  next_pos = 6; end
                     default:     begin n_fields = 30; next_pos = 7; end
                  endcase
                  if (int'(elem_idx) + 1 >= n_fields) enter_from(next_pos);
                  else elem_idx++;
               end
            endcase
            outs.push_back(r);
            fill_pos  = '0;
            shift_reg = '0;
         end
      end
      // end mark: status transaction, then a fresh packet
      if (eop) begin
         r      = '0;
         r.kind = KIND_STATUS;
         if (byte_cnt < min_len) r.status = ST_SHORT;
         else if (cur_sec != SEC_DONE) r.status = ST_TRUNC;
         else r.status = ST_OK;
         outs.push_back(r);
         clear_parser();
      end
      for (int k = 0; k < outs.size(); k++) begin
         r      = outs[k];
         r.last = (k == outs.size() - 1);
         awaited_results.push_back(r);
      end
   endtask

   // little-endian field into the packet under construction
   task automatic put_le(input logic [31:0] v, input int n);
      for (int k = 0; k < n; k++) pkt.push_back(v[8*k +: 8]);
   endtask

   // move the first len bytes of the packet to the send queue
   task automatic send_packet(input int len, input logic nogap, input logic drain_first);
      byte_item_type it;
      for (int k = 0; k < len; k++) begin
         it.data  = pkt[k];
         it.last  = (k == len - 1);
         it.nogap = nogap;
         it.drain = drain_first && (k == 0);
         packet_bytes.push_back(it);
      end
      pkt.delete();
   endtask

   // well-formed packet with random flags and content
   task automatic build_packet();
      logic [15:0] fl;
      int vc, ne;
      fl[15:7] = 9'($urandom);
      for (int p = 0; p < 7; p++) begin
         fl[p] = (p == 4) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 2) == 0);
      end
      put_le($urandom, 4);
      put_le($urandom, 4);
      put_le($urandom, 2);
      put_le($urandom, 2);
      put_le($urandom, 2);
      put_le($urandom, 4);
      put_le(32'(fl), 2);
      if (fl[0]) repeat (20) put_le($urandom, 2);
      if (fl[1]) repeat (30) put_le($urandom, 1);
      if (fl[2]) repeat (8) put_le($urandom, 2);
      if (fl[3]) put_le($urandom, 4);
      if (fl[4]) begin
         case ($urandom_range(0, 9))
            0:       vc = 0;
            1:       vc = $urandom_range(MAX_VIRTUALS + 1, 65535);
            2:       vc = MAX_VIRTUALS;
            default: vc = $urandom_range(1, 4);
         endcase
         put_le(32'(vc), 2);
         ne = (vc > MAX_VIRTUALS) ? MAX_VIRTUALS : vc;
         repeat (ne) begin
            put_le($urandom, 2);
            put_le($urandom, 4);
         end
      end
      if (fl[5]) put_le($urandom, 4);
      if (fl[6]) repeat (30) put_le($urandom, 2);
   endtask

   // driver: one byte transaction at a time from the send queue
   always @(posedge clock) begin : driver
      logic nv;
      byte_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'd0;
         req_tlast  <= 1'b0;
         clear_parser();
         gap_left = 0;
      end else begin
         nv = req_tvalid;
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
            nv = 1'b0;
            draw_wait(drv_run, drv_calm, gap_left);
         end
         if (!nv) begin
            if (packet_bytes.size() != 0 && packet_bytes[0].nogap) gap_left = 0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (packet_bytes.size() != 0 &&
                         !(packet_bytes[0].drain && awaited_results.size() != 0)) begin
               nxt = packet_bytes.pop_front();
               req_tdata <= nxt.data;
               req_tlast <= nxt.last;
               nv = 1'b1;
            end
         end
         req_tvalid <= nv;
      end
   end

   // monitor: compare each result transaction with the oldest awaited one
   always @(posedge clock) begin : monitor
      result_type got, want;
      logic nr;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         nr = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.kind    = kind_type'(rsp_tuser);
            got.section = section_type'(rsp_tdata[3:0]);
            got.idx     = rsp_tdata[9:4];
            got.id      = rsp_tdata[25:10];
            got.value   = rsp_tdata[57:26];
            got.status  = status_type'(rsp_tdata[59:58]);
            got.last    = rsp_tlast;
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result kind=%0d sec=%0d idx=%0d id=%h val=%h st=%0d last=%0d",
                        $time, got.kind, got.section, got.idx, got.id, got.value, got.status,
                        got.last);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               if (got !== want || rsp_tdata[63:60] !== 4'd0) begin
                  $display("%0t: mismatch expected kind=%0d sec=%0d idx=%0d id=%h val=%h st=%0d last=%0d",
                           $time, want.kind, want.section, want.idx, want.id, want.value,
                           want.status, want.last);
                  $display("%0t:          actual kind=%0d sec=%0d idx=%0d id=%h val=%h st=%0d last=%0d pad=%h",
                           $time, got.kind, got.section, got.idx, got.id, got.value, got.status,
                           got.last, rsp_tdata[63:60]);
                  mismatches++;
               end
            end
            nr = 1'b0;
            draw_wait(mon_run, mon_calm, stall_left);
         end
         if (!nr) begin
            if (stall_left > 0) stall_left--;
            else nr = 1'b1;
         end
         rsp_tready <= nr;
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int rand_bytes, len, pick;
      logic first;

      // one byte that ends the packet at once
      pkt.push_back(8'hFF);
      send_packet(1, 1'b0, 1'b0);
      // header alone: extreme values, negative and positive temperatures,
      // only undefined flag bits set, end mark on the flags byte
      put_le(32'hFFFF_FFFF, 4);
      put_le(32'h0000_0000, 4);
      put_le(32'h0000_FFFF, 2);
      put_le(32'h0000_8000, 2);
      put_le(32'h0000_7FFF, 2);
      put_le(32'h8000_0001, 4);
      put_le(32'h0000_FF80, 2);
      send_packet(20, 1'b0, 1'b0);
      // short packet of zeros
      pkt.push_back(8'h00);
      pkt.push_back(8'h00);
      send_packet(2, 1'b0, 1'b0);

      // random packets: mostly well formed, some cut short, some noise
      rand_bytes = 0;
      first = 1'b1;
      while (rand_bytes < 450) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            len = $urandom_range(1, 24);
            repeat (len) pkt.push_back(8'($urandom));
         end else begin
            build_packet();
            if (pick <= 2) begin
               len = $urandom_range(1, pkt.size() - 1);
            end else begin
               repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
               len = pkt.size();
            end
         end
         rand_bytes += len;
         send_packet(len, 1'b0, first);
         first = 1'b0;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (packet_bytes.size() != 0 || req_tvalid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(64'd5_000_000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tpp_pkg.sv
rtl/tpp_front.sv
rtl/tpp_queue.sv
rtl/tpp_back.sv
rtl/telemetry_packet_parser.sv
sim/testbench.sv
